// File: hw/rtl/qrot_pkg.sv
// Package for the quaternion rotation core: payload types and stage widths.
`default_nettype none
package qrot_pkg;

  localparam int RotW   = 16;
  localparam int PtW    = 32;
  localparam int ConjW  = RotW + 1;
  localparam int Prod1W = RotW + PtW;
  localparam int PW     = Prod1W + 2;
  localparam int LowW   = 24;
  localparam int PhW    = PW - LowW;
  localparam int PlW    = LowW + 1;
  localparam int MhW    = PhW + ConjW;
  localparam int MlW    = PlW + ConjW;
  localparam int HsW    = MhW + 2;
  localparam int LsW    = MlW + 2;
  localparam int SumW   = HsW + LowW + 1;
  localparam int FinalShift = 28;
  localparam int QW     = SumW - FinalShift;
  localparam int OutW   = 32;

  typedef logic signed [ConjW-1:0] conj_word_t;
  typedef logic signed [PW-1:0]    p_word_t;
  typedef logic signed [HsW-1:0]   hs_word_t;
  typedef logic signed [LsW-1:0]   ls_word_t;

  typedef struct packed {
    logic signed [RotW-1:0] rot_w;
    logic signed [RotW-1:0] rot_i;
    logic signed [RotW-1:0] rot_j;
    logic signed [RotW-1:0] rot_k;
    logic signed [PtW-1:0]  pt_w;
    logic signed [PtW-1:0]  pt_i;
    logic signed [PtW-1:0]  pt_j;
    logic signed [PtW-1:0]  pt_k;
  } in_t;

  typedef struct packed {
    logic signed [OutW-1:0] out_w;
    logic signed [OutW-1:0] out_i;
    logic signed [OutW-1:0] out_j;
    logic signed [OutW-1:0] out_k;
  } out_t;

  // rot * pt, plus the conjugate of rot
  typedef struct packed {
    p_word_t    [3:0] p;
    conj_word_t [3:0] c;
  } prod1_t;

  // (rot * pt) * conj(rot), as high part times 2^24 plus low part
  typedef struct packed {
    hs_word_t [3:0] hs;
    ls_word_t [3:0] ls;
  } prod2_t;

endpackage
`default_nettype wire

// File: hw/rtl/qrot_mul1.sv
// First Hamilton product rot * pt: product stage and sum stage.
`default_nettype none
module qrot_mul1 import qrot_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire logic   vld_i,
  input  wire in_t    data_i,
  output logic        vld_o,
  output prod1_t      data_o
);

  logic signed [RotW-1:0]   r  [4];
  logic signed [PtW-1:0]    pt [4];
  logic signed [Prod1W-1:0] m_r [4][4];
  conj_word_t               c_r [4];
  logic                     vld1_r, vld2_r;
  p_word_t                  p_nxt [4];
  prod1_t                   data_r;

  assign r[0]  = data_i.rot_w;
  assign r[1]  = data_i.rot_i;
  assign r[2]  = data_i.rot_j;
  assign r[3]  = data_i.rot_k;
  assign pt[0] = data_i.pt_w;
  assign pt[1] = data_i.pt_i;
  assign pt[2] = data_i.pt_j;
  assign pt[3] = data_i.pt_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          m_r[a][b] <= r[a] * pt[b];
        end
      end
      c_r[0] <= ConjW'(r[0]);
      c_r[1] <= -ConjW'(r[1]);
      c_r[2] <= -ConjW'(r[2]);
      c_r[3] <= -ConjW'(r[3]);
    end
  end

  always_comb begin
    p_nxt[0] = PW'(m_r[0][0]) - PW'(m_r[1][1]) - PW'(m_r[2][2]) - PW'(m_r[3][3]);
    p_nxt[1] = PW'(m_r[0][1]) + PW'(m_r[1][0]) + PW'(m_r[2][3]) - PW'(m_r[3][2]);
    p_nxt[2] = PW'(m_r[0][2]) - PW'(m_r[1][3]) + PW'(m_r[2][0]) + PW'(m_r[3][1]);
    p_nxt[3] = PW'(m_r[0][3]) + PW'(m_r[1][2]) - PW'(m_r[2][1]) + PW'(m_r[3][0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 4; n++) begin
        data_r.p[n] <= p_nxt[n];
        data_r.c[n] <= c_r[n];
      end
    end
  end

  assign vld_o  = vld2_r;
  assign data_o = data_r;

endmodule
`default_nettype wire

// File: hw/rtl/qrot_mul2.sv
// Second Hamilton product p * conj(rot), split into high and low halves of p.
`default_nettype none
module qrot_mul2 import qrot_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire logic   vld_i,
  input  wire prod1_t data_i,
  output logic        vld_o,
  output prod2_t      data_o
);

  logic signed [PhW-1:0] ph [4];
  logic signed [PlW-1:0] pl [4];
  conj_word_t            c  [4];
  logic signed [MhW-1:0] mh_r [4][4];
  logic signed [MlW-1:0] ml_r [4][4];
  logic                  vld3_r, vld4_r;
  hs_word_t              hs_nxt [4];
  ls_word_t              ls_nxt [4];
  prod2_t                data_r;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      ph[n] = $signed(data_i.p[n][PW-1:LowW]);
      pl[n] = $signed({1'b0, data_i.p[n][LowW-1:0]});
      c[n]  = $signed(data_i.c[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld_i;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          mh_r[a][b] <= ph[a] * c[b];
          ml_r[a][b] <= pl[a] * c[b];
        end
      end
    end
  end

  always_comb begin
    hs_nxt[0] = HsW'(mh_r[0][0]) - HsW'(mh_r[1][1]) - HsW'(mh_r[2][2]) - HsW'(mh_r[3][3]);
    hs_nxt[1] = HsW'(mh_r[0][1]) + HsW'(mh_r[1][0]) + HsW'(mh_r[2][3]) - HsW'(mh_r[3][2]);
    hs_nxt[2] = HsW'(mh_r[0][2]) - HsW'(mh_r[1][3]) + HsW'(mh_r[2][0]) + HsW'(mh_r[3][1]);
    hs_nxt[3] = HsW'(mh_r[0][3]) + HsW'(mh_r[1][2]) - HsW'(mh_r[2][1]) + HsW'(mh_r[3][0]);
    ls_nxt[0] = LsW'(ml_r[0][0]) - LsW'(ml_r[1][1]) - LsW'(ml_r[2][2]) - LsW'(ml_r[3][3]);
    ls_nxt[1] = LsW'(ml_r[0][1]) + LsW'(ml_r[1][0]) + LsW'(ml_r[2][3]) - LsW'(ml_r[3][2]);
    ls_nxt[2] = LsW'(ml_r[0][2]) - LsW'(ml_r[1][3]) + LsW'(ml_r[2][0]) + LsW'(ml_r[3][1]);
    ls_nxt[3] = LsW'(ml_r[0][3]) + LsW'(ml_r[1][2]) - LsW'(ml_r[2][1]) + LsW'(ml_r[3][0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 4; n++) begin
        data_r.hs[n] <= hs_nxt[n];
        data_r.ls[n] <= ls_nxt[n];
      end
    end
  end

  assign vld_o  = vld4_r;
  assign data_o = data_r;

endmodule
`default_nettype wire

// File: hw/rtl/qrot_round.sv
// Recombine high and low sums, round to nearest (half up), saturate to 32 bits.
`default_nettype none
module qrot_round import qrot_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire logic   vld_i,
  input  wire prod2_t data_i,
  output logic        vld_o,
  output out_t        data_o
);

  localparam logic signed [SumW-1:0] Half = SumW'(1) <<< (FinalShift - 1);
  localparam logic signed [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

  logic signed [SumW-1:0] v_nxt [4];
  logic signed [SumW-1:0] v_r   [4];
  logic signed [QW-1:0]   q     [4];
  logic                   pos_ovf [4];
  logic                   neg_ovf [4];
  logic signed [OutW-1:0] res_nxt [4];
  logic signed [OutW-1:0] res_r   [4];
  logic                   vld5_r, vld6_r;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      v_nxt[n] = (SumW'($signed(data_i.hs[n])) <<< LowW)
                 + SumW'($signed(data_i.ls[n])) + Half;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else if (en) begin
      vld5_r <= vld_i;
      vld6_r <= vld5_r;
    end
  end

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      q[n]       = v_r[n][SumW-1:FinalShift];
      pos_ovf[n] = !q[n][QW-1] && (q[n][QW-2:OutW-1] != '0);
      neg_ovf[n] = q[n][QW-1] && (q[n][QW-2:OutW-1] != '1);
      if (pos_ovf[n]) begin
        res_nxt[n] = OutMax;
      end else if (neg_ovf[n]) begin
        res_nxt[n] = OutMin;
      end else begin
        res_nxt[n] = q[n][OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 4; n++) begin
        v_r[n]   <= v_nxt[n];
        res_r[n] <= res_nxt[n];
      end
    end
  end

  assign vld_o        = vld6_r;
  assign data_o.out_w = res_r[0];
  assign data_o.out_i = res_r[1];
  assign data_o.out_j = res_r[2];
  assign data_o.out_k = res_r[3];

`ifndef SYNTH
  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld5_r && pos_ovf[0] |=> data_o.out_w == OutMax)
    else $error("positive overflow not clamped");
  a_neg_sat: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld5_r && neg_ovf[1] |=> data_o.out_i == OutMin)
    else $error("negative overflow not clamped");
  a_vld_flow: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld5_r |=> vld_o)
    else $error("valid lost in final stage");
  a_vld_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld5_r) && $stable(vld_o))
    else $error("valid moved during stall");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/quaternion_rotate_core.sv
// Top level of the quaternion rotation core.
// Computes rot * pt * conj(rot) exactly and rounds the result to Q16.16 with
// saturation. Fully pipelined: one request per cycle, with two stages per
// Hamilton product and two for recombine/round/saturate. The whole pipeline
// advances together; when a result is held by out_ready low, in_ready drops
// until it is taken.
`default_nettype none
module quaternion_rotate_core import qrot_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic   en;
  logic   vld_a, vld_b;
  prod1_t p1;
  prod2_t p2;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  qrot_mul1 u_mul1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .data_i (in_data),
    .vld_o  (vld_a),
    .data_o (p1)
  );

  qrot_mul2 u_mul2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld_a),
    .data_i (p1),
    .vld_o  (vld_b),
    .data_o (p2)
  );

  qrot_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld_b),
    .data_i (p2),
    .vld_o  (out_valid),
    .data_o (out_data)
  );

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for quaternion_rotate_core: directed table, then random requests.
module testbench;
  import qrot_pkg::*;

  localparam int NumRandom  = 1650;
  localparam int CycleLimit = 400000;
  localparam int LongHold   = 250;

  typedef logic signed [95:0] wide_t;
  typedef struct packed {
    wide_t w;
    wide_t i;
    wide_t j;
    wide_t k;
  } quat_t;
  typedef struct packed {
    in_t  req;
    logic typed;
    out_t want;
  } dir_row_t;
  typedef enum int {MIX_FULL, MIX_UNIT, MIX_EXTREME, MIX_VECTOR} mix_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t rotated_q [$];
  out_t next_rotated;
  int   errors        = 0;
  int   cycle_count   = 0;
  int   tx_quiet_left = 0;
  int   rx_quiet_left = 0;
  bit   hold_off_req  = 1'b0;

  logic [15:0] rot_picks [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000};
  logic [31:0] pt_picks [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000};

  quaternion_rotate_core uut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data
  );

  always #2 clk = ~clk;

  function automatic quat_t hamilton(quat_t a, quat_t b);
    quat_t o;
    o.w = a.w * b.w - a.i * b.i - a.j * b.j - a.k * b.k;
    o.i = a.w * b.i + a.i * b.w + a.j * b.k - a.k * b.j;
    o.j = a.w * b.j - a.i * b.k + a.j * b.w + a.k * b.i;
    o.k = a.w * b.k + a.i * b.j - a.j * b.i + a.k * b.w;
    return o;
  endfunction

  // 2^-44 units in, Q16.16 out: round half up, then clamp
  function automatic logic [31:0] round_sat(wide_t x);
    wide_t half, y, hi_lim, lo_lim;
    half = '0;
    half[27] = 1'b1;
    hi_lim = 2147483647;
    lo_lim = -hi_lim - 1;
    y = (x + half) >>> 28;
    if (y > hi_lim) begin
      y = hi_lim;
    end else if (y < lo_lim) begin
      y = lo_lim;
    end
    return y[31:0];
  endfunction

  function automatic out_t rotate_point(in_t d);
    quat_t r, c, v, p, q;
    out_t  o;
    r.w = d.rot_w;
    r.i = d.rot_i;
    r.j = d.rot_j;
    r.k = d.rot_k;
    c.w = r.w;
    c.i = -r.i;
    c.j = -r.j;
    c.k = -r.k;
    v.w = d.pt_w;
    v.i = d.pt_i;
    v.j = d.pt_j;
    v.k = d.pt_k;
    p = hamilton(r, v);
    q = hamilton(p, c);
    o.out_w = round_sat(q.w);
    o.out_i = round_sat(q.i);
    o.out_j = round_sat(q.j);
    o.out_k = round_sat(q.k);
    return o;
  endfunction

  function automatic dir_row_t mk_row(logic [63:0] rot, logic [127:0] pt, logic typed,
                                      logic [127:0] want);
    dir_row_t row;
    row.req   = {rot, pt};
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic logic [31:0] small_pt();
    logic [31:0] r;
    r = $urandom;
    return {{7{r[24]}}, r[24:0]};
  endfunction

  function automatic in_t random_request();
    in_t  d;
    mix_t mix;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      mix = MIX_FULL;
    end else if (pick < 70) begin
      mix = MIX_UNIT;
    end else if (pick < 85) begin
      mix = MIX_EXTREME;
    end else begin
      mix = MIX_VECTOR;
    end
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case (mix)
      MIX_UNIT, MIX_VECTOR: begin
        d.rot_w = 16'($urandom_range(0, 32768) - 16384);
        d.rot_i = 16'($urandom_range(0, 32768) - 16384);
        d.rot_j = 16'($urandom_range(0, 32768) - 16384);
        d.rot_k = 16'($urandom_range(0, 32768) - 16384);
        d.pt_w  = (mix == MIX_VECTOR) ? '0 : small_pt();
        d.pt_i  = small_pt();
        d.pt_j  = small_pt();
        d.pt_k  = small_pt();
      end
      MIX_EXTREME: begin
        d.rot_w = rot_picks[$urandom_range(0, 5)];
        d.rot_i = rot_picks[$urandom_range(0, 5)];
        d.rot_j = rot_picks[$urandom_range(0, 5)];
        d.rot_k = rot_picks[$urandom_range(0, 5)];
        d.pt_w  = pt_picks[$urandom_range(0, 5)];
        d.pt_i  = pt_picks[$urandom_range(0, 5)];
        d.pt_j  = pt_picks[$urandom_range(0, 5)];
        d.pt_k  = pt_picks[$urandom_range(0, 5)];
      end
      default: begin
      end
    endcase
    return d;
  endfunction

  task automatic send_request(in_t d, out_t want);
    int gap;
    if (tx_quiet_left > 0) begin
      tx_quiet_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 49) == 0) tx_quiet_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    rotated_q.push_back(want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (rotated_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (rotated_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, got %h", $time, out_data);
      end else begin
        next_rotated = rotated_q.pop_front();
        check_field("out_w", next_rotated.out_w, out_data.out_w);
        check_field("out_i", next_rotated.out_i, out_data.out_i);
        check_field("out_j", next_rotated.out_j, out_data.out_j);
        check_field("out_k", next_rotated.out_k, out_data.out_k);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = LongHold;
      end else if (rx_quiet_left > 0) begin
        rx_quiet_left--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 14);
        if ($urandom_range(0, 49) == 0) rx_quiet_left = $urandom_range(20, 60);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    dir_row_t dir_rows [$];
    in_t      req;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows.push_back(mk_row(64'h0, 128'h0, 1'b1, 128'h0));
    // identity rotation passes the point through
    dir_rows.push_back(mk_row(64'h4000_0000_0000_0000,
                              128'h0005_0000_0001_0000_0002_0000_0003_0000, 1'b1,
                              128'h0005_0000_0001_0000_0002_0000_0003_0000));
    dir_rows.push_back(mk_row(64'h4000_0000_0000_0000,
                              128'h7FFF_FFFF_8000_0000_FFFF_FFFF_0000_0001, 1'b1,
                              128'h7FFF_FFFF_8000_0000_FFFF_FFFF_0000_0001));
    // w = -2.0 scales by 4 and saturates
    dir_rows.push_back(mk_row(64'h8000_0000_0000_0000,
                              128'h7FFF_FFFF_8000_0000_0001_0000_FFFF_0000, 1'b1,
                              128'h7FFF_FFFF_8000_0000_0004_0000_FFFC_0000));
    // half turn about i; negating the most negative j saturates high
    dir_rows.push_back(mk_row(64'h0000_4000_0000_0000,
                              128'h0005_0000_0001_0000_8000_0000_0003_0000, 1'b1,
                              128'h0005_0000_0001_0000_7FFF_FFFF_FFFD_0000));
    // i = -2.0: conjugate of the most negative component
    dir_rows.push_back(mk_row(64'h0000_8000_0000_0000,
                              128'h0001_0000_0001_0000_0001_0000_0001_0000, 1'b1,
                              128'h0004_0000_0004_0000_FFFC_0000_FFFC_0000));
    // tiny rotation: rounding of exact halves and near halves
    dir_rows.push_back(mk_row(64'h0001_0000_0000_0000,
                              128'h0800_0000_F800_0000_1800_0000_07FF_FFFF, 1'b1,
                              128'h0000_0001_0000_0000_0000_0002_0000_0000));
    dir_rows.push_back(mk_row(64'h0001_0000_0000_0000,
                              128'hE800_0000_7FFF_FFFF_8000_0000_0000_0000, 1'b1,
                              128'hFFFF_FFFF_0000_0008_FFFF_FFF8_0000_0000));
    dir_rows.push_back(mk_row(64'h8000_8000_8000_8000,
                              128'h7FFF_FFFF_7FFF_FFFF_7FFF_FFFF_7FFF_FFFF, 1'b0, 128'h0));
    dir_rows.push_back(mk_row(64'h7FFF_7FFF_7FFF_7FFF,
                              128'h8000_0000_8000_0000_8000_0000_8000_0000, 1'b0, 128'h0));
    dir_rows.push_back(mk_row(64'h8000_8000_8000_8000,
                              128'h8000_0000_8000_0000_8000_0000_8000_0000, 1'b0, 128'h0));
    dir_rows.push_back(mk_row(64'h2D41_0000_2D41_0000,
                              128'h0000_0000_0001_0000_0002_0000_0003_0000, 1'b0, 128'h0));
    dir_rows.push_back(mk_row(64'h2D41_0000_0000_2D41,
                              128'h7FFF_FFFF_7FFF_FFFF_8000_0000_0001_0000, 1'b0, 128'h0));
    dir_rows.push_back(mk_row(64'hFFFF_0001_FFFF_0001,
                              128'h1234_5678_9ABC_DEF0_0FED_CBA9_8765_4321, 1'b0, 128'h0));
    dir_rows.push_back(mk_row(64'h7FFF_8000_7FFF_8000,
                              128'h0000_0001_FFFF_FFFF_0000_0001_FFFF_FFFF, 1'b0, 128'h0));
    dir_rows.push_back(mk_row(64'hFFFF_FFFF_FFFF_FFFF,
                              128'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF, 1'b0, 128'h0));

    foreach (dir_rows[idx]) begin
      send_request(dir_rows[idx].req,
                   dir_rows[idx].typed ? dir_rows[idx].want : rotate_point(dir_rows[idx].req));
    end
    drain();

    for (int idx = 0; idx < NumRandom; idx++) begin
      if (idx == 400) begin
        hold_off_req  = 1'b1;
        tx_quiet_left = 80;
      end
      if (idx == 900) drain();
      req = random_request();
      send_request(req, rotate_point(req));
    end
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0 && rotated_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
